### sv/scfrc_pkg.sv
// ============================================================================
// scfrc_pkg
// Shared types, codes and constants of the size-class free-rectangle cache.
// ============================================================================
package scfrc_pkg;

   // Fixed geometry of the cache.
   localparam int MAX_SIDE         = 8;
   localparam int DIRECTIONS       = 4;
   localparam int SIDE_BITS        = 3;
   localparam int DIR_BITS         = 2;
   localparam int CLASS_BITS       = 2 * SIDE_BITS;
   localparam int NUM_CLASSES      = MAX_SIDE * MAX_SIDE;
   localparam int BUCKET_BITS      = DIR_BITS + CLASS_BITS;
   localparam int NUM_BUCKETS      = DIRECTIONS * NUM_CLASSES;

   // Field widths of the items.
   localparam int KIND_BITS        = 2;
   localparam int SIZE_BITS        = 4;
   localparam int IDX_BITS         = 4;
   localparam int COORD_FIELD_BITS = 8;
   localparam int STATUS_BITS      = 3;
   localparam int CNT_FIELD_BITS   = 5;

   // Defaults of the top-level parameters.
   localparam int BUCKET_DEPTH_DEF = 16;
   localparam int COORD_BITS_DEF   = 8;

   // Operation codes.
   localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FIND   = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd3;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NO_FIT    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_RANGE     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_BAD_SIZE  = 3'd4;

   typedef struct packed {
      logic [KIND_BITS-1:0]        kind;
      logic [DIR_BITS-1:0]         dir;
      logic [SIZE_BITS-1:0]        rect_width;
      logic [SIZE_BITS-1:0]        rect_height;
      logic [IDX_BITS-1:0]         entry_index;
      logic [COORD_FIELD_BITS-1:0] pos_x;
      logic [COORD_FIELD_BITS-1:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]      status;
      logic [SIZE_BITS-1:0]        found_width;
      logic [SIZE_BITS-1:0]        found_height;
      logic [CNT_FIELD_BITS-1:0]   entry_count;
      logic [COORD_FIELD_BITS-1:0] out_x;
      logic [COORD_FIELD_BITS-1:0] out_y;
      logic                        now_empty;
   } rsp_type;

   // Update of one occupancy bit.
   typedef struct packed {
      logic                  set;
      logic                  clr;
      logic [DIR_BITS-1:0]   dir;
      logic [CLASS_BITS-1:0] cls;
   } occ_upd_type;

   // Result of the find-fit search.
   typedef struct packed {
      logic                  hit;
      logic [CLASS_BITS-1:0] cls;
   } fit_type;

endpackage

### sv/scfrc_cnt_ram.sv
// ============================================================================
// scfrc_cnt_ram
// Bucket count memory with one valid bit per bucket; unwritten buckets read 0.
// ============================================================================
module scfrc_cnt_ram #(
   parameter int CW = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [scfrc_pkg::BUCKET_BITS-1:0] rd_addr,
   output logic [CW-1:0]                   rd_data,
   input  logic                            wr_en,
   input  logic [scfrc_pkg::BUCKET_BITS-1:0] wr_addr,
   input  logic [CW-1:0]                   wr_data
);
   import scfrc_pkg::*;

   logic [CW-1:0]          cnt_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] valid_ff, valid_in;
   logic [CW-1:0]          q_ff;
   logic                   q_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            q_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= cnt_mem[rd_addr];
      end
   end

   assign rd_data = q_valid_ff ? q_ff : '0;

endmodule

### sv/scfrc_pos_ram.sv
// ============================================================================
// scfrc_pos_ram
// Position store: one x,y pair per bucket slot, registered read.
// ============================================================================
module scfrc_pos_ram #(
   parameter int PW = 8,
   parameter int SW = 4
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [scfrc_pkg::BUCKET_BITS+SW-1:0] rd_addr,
   output logic [2*PW-1:0]                      rd_data,
   input  logic                                 wr_en,
   input  logic [scfrc_pkg::BUCKET_BITS+SW-1:0] wr_addr,
   input  logic [2*PW-1:0]                      wr_data
);
   import scfrc_pkg::*;

   localparam int DEPTH = NUM_BUCKETS * (1 << SW);

   logic [2*PW-1:0] pos_mem [DEPTH];
   logic [2*PW-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= pos_mem[rd_addr];
      end
   end

   assign rd_data = q_ff;

endmodule

### sv/scfrc_occ.sv
// ============================================================================
// scfrc_occ
// Occupancy words per direction and the find-fit priority search.
// ============================================================================
module scfrc_occ (
   input  logic                             clock,
   input  logic                             reset,
   input  scfrc_pkg::occ_upd_type           upd,
   input  logic [scfrc_pkg::DIR_BITS-1:0]   fdir,
   input  logic [scfrc_pkg::SIDE_BITS-1:0]  fw_m1,
   input  logic [scfrc_pkg::SIDE_BITS-1:0]  fh_m1,
   output scfrc_pkg::fit_type               fit
);
   import scfrc_pkg::*;

   logic [NUM_CLASSES-1:0] occ_ff [DIRECTIONS];
   logic [NUM_CLASSES-1:0] occ_in [DIRECTIONS];
   logic [NUM_CLASSES-1:0] cand;

   // Classes at least as wide and as tall as the request.
   function automatic logic [NUM_CLASSES-1:0] dom_mask(
      input logic [SIDE_BITS-1:0] w_m1,
      input logic [SIDE_BITS-1:0] h_m1
   );
      logic [NUM_CLASSES-1:0] m;
      int r;
      int c;
      m = '0;
      for (r = 0; r < MAX_SIDE; r++) begin
         for (c = 0; c < MAX_SIDE; c++) begin
            m[r*MAX_SIDE+c] = (SIDE_BITS'(c) >= w_m1) && (SIDE_BITS'(r) >= h_m1);
         end
      end
      return m;
   endfunction

   // Lowest set bit: first the lowest non-empty row, then the column in it.
   function automatic fit_type lowest_set(input logic [NUM_CLASSES-1:0] v);
      logic [MAX_SIDE-1:0]  nz;
      logic [MAX_SIDE-1:0]  row_bits;
      logic [SIDE_BITS-1:0] row;
      logic [SIDE_BITS-1:0] col;
      fit_type              f;
      int i;
      for (i = 0; i < MAX_SIDE; i++) begin
         nz[i] = |v[i*MAX_SIDE +: MAX_SIDE];
      end
      row = '0;
      for (i = MAX_SIDE - 1; i >= 0; i--) begin
         if (nz[i]) begin
            row = SIDE_BITS'(i);
         end
      end
      row_bits = v[{row, {SIDE_BITS{1'b0}}} +: MAX_SIDE];
      col = '0;
      for (i = MAX_SIDE - 1; i >= 0; i--) begin
         if (row_bits[i]) begin
            col = SIDE_BITS'(i);
         end
      end
      f.hit = |nz;
      f.cls = {row, col};
      return f;
   endfunction

   always_comb begin
      for (int d = 0; d < DIRECTIONS; d++) begin
         occ_in[d] = occ_ff[d];
      end
      if (upd.set) begin
         occ_in[upd.dir][upd.cls] = 1'b1;
      end
      if (upd.clr) begin
         occ_in[upd.dir][upd.cls] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < DIRECTIONS; d++) begin
            occ_ff[d] <= '0;
         end
      end else begin
         for (int d = 0; d < DIRECTIONS; d++) begin
            occ_ff[d] <= occ_in[d];
         end
      end
   end

   assign cand = occ_ff[fdir] & dom_mask(fw_m1, fh_m1);
   assign fit  = lowest_set(cand);

endmodule

### sv/size_class_free_rect_cache_top.sv
// ============================================================================
// size_class_free_rect_cache_top
// Free-rectangle cache filed by direction and size class, with find-fit.
// ============================================================================
// Usage:
// The req_ channel carries one operation item (insert, find-fit, read entry,
// remove entry); the rsp_ channel returns exactly one result item for each.
// Both channels use valid/ready; an item moves when valid and ready are high
// at the same rising edge.
// The block works on one item at a time. Insert, find-fit and any item with a
// bad size load the result register from the execute step; read and remove
// load it from the position step that follows. The count memory sets this
// order: its value is read in the accept cycle and written back in the next
// one, and read and remove add one access to the position memory. A new item
// is taken only once the previous result has reached the output register.
// req_ready is high whenever no item is in work. A finished result that the
// receiver has not yet taken stays in the output register; the next one
// waits in a holding register and the block takes no new item until it moves.
// Synchronous reset clears the occupancy words, the valid bits of all bucket
// counts and both channels at once; no clearing pass is needed. The position
// store is not cleared, since only entries below a bucket's count are read.
// ============================================================================
module size_class_free_rect_cache_top #(
   parameter int BUCKET_DEPTH = scfrc_pkg::BUCKET_DEPTH_DEF,
   parameter int COORD_BITS   = scfrc_pkg::COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  scfrc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output scfrc_pkg::rsp_type rsp_data
);
   import scfrc_pkg::*;

   // Count width, slot address width, stored coordinate width.
   localparam int CW = $clog2(BUCKET_DEPTH + 1);
   localparam int SW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int PW = (COORD_BITS < COORD_FIELD_BITS) ? COORD_BITS : COORD_FIELD_BITS;
   localparam int XW = (CW > IDX_BITS) ? CW : IDX_BITS;
   localparam int AW = BUCKET_BITS + SW;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_POS  = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0] state_ff, state_in;
   req_type    req_ff, req_in;
   fit_type    fit_ff, fit_in;
   rsp_type    part_ff, part_in;
   rsp_type    hold_ff, hold_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   logic                   out_free;
   logic [SIZE_BITS-1:0]   acc_w_m1, acc_h_m1;
   logic [SIZE_BITS-1:0]   ex_w_m1, ex_h_m1;
   logic [BUCKET_BITS-1:0] ex_bucket;
   logic                   ex_bad;
   fit_type                fit_c;
   occ_upd_type            occ_upd;

   logic                   cnt_re;
   logic [BUCKET_BITS-1:0] cnt_ra;
   logic [CW-1:0]          cnt_q;
   logic                   cnt_we;
   logic [CW-1:0]          cnt_wd;
   logic [CW-1:0]          cnt_inc, cnt_dec;
   logic                   cnt_full, idx_bad;

   logic                   pos_re, pos_we;
   logic [AW-1:0]          pos_ra, pos_wa;
   logic [2*PW-1:0]        pos_q, pos_wd;

   logic                   fin;
   rsp_type                res;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Accept-cycle decode: the count read goes out with the incoming item.
   assign acc_w_m1 = req_data.rect_width - SIZE_BITS'(1);
   assign acc_h_m1 = req_data.rect_height - SIZE_BITS'(1);
   assign cnt_re   = accept;
   assign cnt_ra   = (req_data.kind == KIND_FIND) ?
                     {req_data.dir, fit_c.cls} :
                     {req_data.dir, acc_h_m1[SIDE_BITS-1:0], acc_w_m1[SIDE_BITS-1:0]};

   // Execute-cycle decode of the held item.
   assign ex_w_m1   = req_ff.rect_width - SIZE_BITS'(1);
   assign ex_h_m1   = req_ff.rect_height - SIZE_BITS'(1);
   assign ex_bucket = {req_ff.dir, ex_h_m1[SIDE_BITS-1:0], ex_w_m1[SIDE_BITS-1:0]};
   assign ex_bad    = (req_ff.rect_width == '0) ||
                      (req_ff.rect_width > SIZE_BITS'(MAX_SIDE)) ||
                      (req_ff.rect_height == '0) ||
                      (req_ff.rect_height > SIZE_BITS'(MAX_SIDE));
   assign cnt_inc   = cnt_q + CW'(1);
   assign cnt_dec   = cnt_q - CW'(1);
   assign cnt_full  = cnt_q >= CW'(BUCKET_DEPTH);
   assign idx_bad   = XW'(req_ff.entry_index) >= XW'(cnt_q);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      fit_in       = fit_ff;
      part_in      = part_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cnt_we       = 1'b0;
      cnt_wd       = cnt_inc;
      pos_re       = 1'b0;
      pos_ra       = {ex_bucket, SW'(req_ff.entry_index)};
      pos_we       = 1'b0;
      pos_wa       = {ex_bucket, SW'(cnt_q)};
      pos_wd       = {req_ff.pos_x[PW-1:0], req_ff.pos_y[PW-1:0]};
      occ_upd      = '0;
      occ_upd.dir  = req_ff.dir;
      occ_upd.cls  = ex_bucket[CLASS_BITS-1:0];
      fin          = 1'b0;
      res          = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               fit_in   = fit_c;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (ex_bad) begin
               res.status = ST_BAD_SIZE;
               fin        = 1'b1;
            end else begin
               case (req_ff.kind)
                  KIND_INSERT: begin
                     fin = 1'b1;
                     if (cnt_full) begin
                        res.status      = ST_FULL;
                        res.entry_count = CNT_FIELD_BITS'(cnt_q);
                     end else begin
                        pos_we          = 1'b1;
                        cnt_we          = 1'b1;
                        cnt_wd          = cnt_inc;
                        occ_upd.set     = 1'b1;
                        res.entry_count = CNT_FIELD_BITS'(cnt_inc);
                     end
                  end
                  KIND_FIND: begin
                     fin = 1'b1;
                     if (!fit_ff.hit) begin
                        res.status = ST_NO_FIT;
                     end else begin
                        res.found_width  = SIZE_BITS'(fit_ff.cls[SIDE_BITS-1:0]) +
                                           SIZE_BITS'(1);
                        res.found_height = SIZE_BITS'(fit_ff.cls[CLASS_BITS-1:SIDE_BITS]) +
                                           SIZE_BITS'(1);
                        res.entry_count  = CNT_FIELD_BITS'(cnt_q);
                     end
                  end
                  KIND_READ: begin
                     res.entry_count = CNT_FIELD_BITS'(cnt_q);
                     if (idx_bad) begin
                        res.status = ST_RANGE;
                        fin        = 1'b1;
                     end else begin
                        pos_re   = 1'b1;
                        part_in  = res;
                        state_in = S_POS;
                     end
                  end
                  default: begin
                     // Remove: the last entry moves into the removed slot.
                     if (idx_bad) begin
                        res.status      = ST_RANGE;
                        res.entry_count = CNT_FIELD_BITS'(cnt_q);
                        fin             = 1'b1;
                     end else begin
                        pos_re          = 1'b1;
                        pos_ra          = {ex_bucket, SW'(cnt_dec)};
                        cnt_we          = 1'b1;
                        cnt_wd          = cnt_dec;
                        occ_upd.clr     = (cnt_dec == '0);
                        res.entry_count = CNT_FIELD_BITS'(cnt_dec);
                        res.now_empty   = (cnt_dec == '0);
                        part_in         = res;
                        state_in        = S_POS;
                     end
                  end
               endcase
            end
         end
         S_POS: begin
            fin = 1'b1;
            res = part_ff;
            if (req_ff.kind == KIND_READ) begin
               res.out_x = COORD_FIELD_BITS'(pos_q[2*PW-1:PW]);
               res.out_y = COORD_FIELD_BITS'(pos_q[PW-1:0]);
            end else begin
               pos_we = 1'b1;
               pos_wa = {ex_bucket, SW'(req_ff.entry_index)};
               pos_wd = pos_q;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A finished result goes straight out, or waits if the output is busy.
      if (fin) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            hold_in  = res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      fit_ff  <= fit_in;
      part_ff <= part_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   scfrc_occ u_occ (
      .clock (clock),
      .reset (reset),
      .upd   (occ_upd),
      .fdir  (req_data.dir),
      .fw_m1 (acc_w_m1[SIDE_BITS-1:0]),
      .fh_m1 (acc_h_m1[SIDE_BITS-1:0]),
      .fit   (fit_c)
   );

   scfrc_cnt_ram #(
      .CW (CW)
   ) u_cnt_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (cnt_re),
      .rd_addr (cnt_ra),
      .rd_data (cnt_q),
      .wr_en   (cnt_we),
      .wr_addr (ex_bucket),
      .wr_data (cnt_wd)
   );

   scfrc_pos_ram #(
      .PW (PW),
      .SW (SW)
   ) u_pos_ram (
      .clock   (clock),
      .rd_en   (pos_re),
      .rd_addr (pos_ra),
      .rd_data (pos_q),
      .wr_en   (pos_we),
      .wr_addr (pos_wa),
      .wr_data (pos_wd)
   );

`ifndef SYNTHESIS
   // An accepted item always moves to the execute step next.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted item did not enter execute");

   // A held result exists only while the output register is occupied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff)
      else $error("result held with a free output register");

   // One occupancy bit is never set and cleared by the same item.
   assert property (@(posedge clock) disable iff (reset)
      !(occ_upd.set && occ_upd.clr))
      else $error("occupancy set and clear together");

   // A bucket count written back never exceeds the bucket depth.
   assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (cnt_wd <= CW'(BUCKET_DEPTH)))
      else $error("bucket count beyond depth");

   // The slot write after a position read belongs to a remove only.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_POS) && pos_we) |-> (req_ff.kind == KIND_REMOVE))
      else $error("position write in read step of a non-remove item");
`endif

endmodule

### dv/size_class_free_rect_cache_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// size_class_free_rect_cache_top_test
// Self-checking bench for the size-class free-rectangle cache.
// A short table of operations runs first: empty-cache lookups, bad sizes,
// the extreme classes and coordinates, and a bucket filled until it reports
// full. Random operations follow, aimed at a few hot buckets so that they
// fill and drain. A shadow copy of the cache predicts each result that a plan row does not give.
// ============================================================================
module size_class_free_rect_cache_top_test;
   import scfrc_pkg::*;

   localparam int DEPTH      = BUCKET_DEPTH_DEF;
   localparam int RAND_ITEMS = 1000;
   localparam int IDLE_LIMIT = 300;
   localparam int DRAIN_WAIT = 10;

   // One row of the directed plan. A typed row carries its own result; any
   // other row is checked against the shadow cache.
   typedef struct packed {
      req_type    req;
      logic       typed;
      rsp_type    rsp;
      logic [4:0] reps;
   } plan_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;

   // Shadow copy of the cache contents.
   logic [63:0] shadow_occ [DIRECTIONS];
   int          shadow_cnt [NUM_BUCKETS];
   logic [7:0]  shadow_x   [NUM_BUCKETS * DEPTH];
   logic [7:0]  shadow_y   [NUM_BUCKETS * DEPTH];

   // Results owed by the block, oldest first.
   rsp_type rsp_owed [$];
   int      errors = 0;

   // Random stimulus focuses on one direction and two classes at a time.
   logic [1:0] hot_dir;
   logic [3:0] hot_w [2];
   logic [3:0] hot_h [2];

   size_class_free_rect_cache_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic req_type op_item(logic [1:0] kind, logic [1:0] dir, int w, int h,
                                       int idx, int x, int y);
      req_type r;
      r.kind        = kind;
      r.dir         = dir;
      r.rect_width  = w[3:0];
      r.rect_height = h[3:0];
      r.entry_index = idx[3:0];
      r.pos_x       = x[7:0];
      r.pos_y       = y[7:0];
      return r;
   endfunction

   function automatic rsp_type result_item(logic [2:0] status, int fw, int fh, int cnt,
                                           int x, int y, bit empty);
      rsp_type o;
      o.status       = status;
      o.found_width  = fw[3:0];
      o.found_height = fh[3:0];
      o.entry_count  = cnt[4:0];
      o.out_x        = x[7:0];
      o.out_y        = y[7:0];
      o.now_empty    = empty;
      return o;
   endfunction

   // Applies one operation to the shadow cache and returns the result the
   // block must give for it.
   function automatic rsp_type shadow_cache_op(req_type r);
      rsp_type     o;
      int          cls, b, base, cnt, f;
      logic [63:0] fits;
      o = '0;
      if (r.rect_width < 1 || r.rect_width > MAX_SIDE ||
          r.rect_height < 1 || r.rect_height > MAX_SIDE) begin
         o.status = ST_BAD_SIZE;
         return o;
      end
      cls  = (r.rect_width - 1) + (r.rect_height - 1) * MAX_SIDE;
      b    = r.dir * NUM_CLASSES + cls;
      base = b * DEPTH;
      cnt  = shadow_cnt[b];
      case (r.kind)
         KIND_INSERT: begin
            if (cnt >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               shadow_x[base + cnt] = r.pos_x;
               shadow_y[base + cnt] = r.pos_y;
               cnt++;
               shadow_cnt[b] = cnt;
               shadow_occ[r.dir][cls] = 1'b1;
            end
         end
         KIND_FIND: begin
            // Keep only classes at least as wide and as tall as asked for.
            fits = '0;
            for (f = 0; f < NUM_CLASSES; f++)
               fits[f] = shadow_occ[r.dir][f] && (f % MAX_SIDE) >= r.rect_width - 1 &&
                         (f / MAX_SIDE) >= r.rect_height - 1;
            if (fits == '0) begin
               o.status = ST_NO_FIT;
               cnt = 0;
            end else begin
               f = 0;
               while (!fits[f]) f++;
               o.found_width  = 4'(f % MAX_SIDE + 1);
               o.found_height = 4'(f / MAX_SIDE + 1);
               cnt = shadow_cnt[r.dir * NUM_CLASSES + f];
            end
         end
         KIND_READ: begin
            if (r.entry_index >= cnt) begin
               o.status = ST_RANGE;
            end else begin
               o.out_x = shadow_x[base + r.entry_index];
               o.out_y = shadow_y[base + r.entry_index];
            end
         end
         default: begin
            if (r.entry_index >= cnt) begin
               o.status = ST_RANGE;
            end else begin
               // The last entry fills the hole left by the removed one.
               shadow_x[base + r.entry_index] = shadow_x[base + cnt - 1];
               shadow_y[base + r.entry_index] = shadow_y[base + cnt - 1];
               cnt--;
               shadow_cnt[b] = cnt;
               if (cnt == 0) begin
                  shadow_occ[r.dir][cls] = 1'b0;
                  o.now_empty = 1'b1;
               end
            end
         end
      endcase
      o.entry_count = cnt[4:0];
      return o;
   endfunction

   // Draws one random operation. Nearly half the items hit the hot buckets
   // with a sensible size, and most indices lie below the current count; the
   // rest are spread widely, and a tenth carry sizes that may be out of range.
   function automatic req_type draw_op();
      req_type r;
      int      p, k, cnt;
      p = $urandom_range(0, 99);
      r.kind = p < 40 ? KIND_INSERT : p < 60 ? KIND_FIND : p < 80 ? KIND_READ : KIND_REMOVE;
      r.dir  = 2'($urandom_range(0, DIRECTIONS - 1));
      if ($urandom_range(0, 9) == 0) begin
         r.rect_width  = 4'($urandom_range(0, 15));
         r.rect_height = 4'($urandom_range(0, 15));
      end else if ($urandom_range(0, 1) == 0) begin
         k = $urandom_range(0, 1);
         r.dir         = hot_dir;
         r.rect_width  = hot_w[k];
         r.rect_height = hot_h[k];
      end else begin
         r.rect_width  = 4'($urandom_range(1, MAX_SIDE));
         r.rect_height = 4'($urandom_range(1, MAX_SIDE));
      end
      cnt = 0;
      if (r.rect_width >= 1 && r.rect_width <= MAX_SIDE &&
          r.rect_height >= 1 && r.rect_height <= MAX_SIDE)
         cnt = shadow_cnt[r.dir * NUM_CLASSES + (r.rect_width - 1) +
                          (r.rect_height - 1) * MAX_SIDE];
      if (cnt > 0 && $urandom_range(0, 4) != 0)
         r.entry_index = 4'($urandom_range(0, cnt - 1));
      else
         r.entry_index = 4'($urandom_range(0, 15));
      r.pos_x = 8'($urandom_range(0, 255));
      r.pos_y = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // Presents one item after a random gap (none when calm is set), or after every
   // owed result has come back when drain is set, and records what it must produce.
   task automatic send_item(req_type r, bit drain, bit calm, bit typed, rsp_type typed_rsp);
      int      gap;
      rsp_type predicted;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (drain || gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         if (drain) begin
            while (rsp_owed.size() != 0) @(negedge clock);
         end else begin
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predicted = shadow_cache_op(r);
      rsp_owed = {rsp_owed, (typed ? typed_rsp : predicted)};
   endtask

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         errors++;
      end
   endtask

   // Result checker: every accepted result is matched against the oldest
   // owed one.
   always @(posedge clock) begin
      rsp_type owed;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_owed.size() == 0) begin
            $error("result item arrived with nothing owed: %h", rsp_data);
            errors++;
         end else begin
            owed = rsp_owed.pop_front();
            check_field("status", owed.status, rsp_data.status);
            check_field("found_width", owed.found_width, rsp_data.found_width);
            check_field("found_height", owed.found_height, rsp_data.found_height);
            check_field("entry_count", owed.entry_count, rsp_data.entry_count);
            check_field("out_x", owed.out_x, rsp_data.out_x);
            check_field("out_y", owed.out_y, rsp_data.out_y);
            check_field("now_empty", owed.now_empty, rsp_data.now_empty);
         end
      end
   end

   // Receiver: drops rsp_ready for a random stall before taking each result,
   // with calm stretches where it takes every result at once.
   initial begin
      int  stall, taken;
      bit  calm;
      taken = 0;
      calm  = 1'b0;
      wait (!reset);
      forever begin
         if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   // Watchdog: a run that stops moving items on both channels has hung.
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle = 0;
         else
            idle++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Main sequence: reset, the directed plan, then the random operations.
   initial begin
      plan_row_type plan [$];
      plan_row_type row;
      int           i, n;
      bit           calm;

      foreach (shadow_occ[d]) shadow_occ[d] = '0;
      foreach (shadow_cnt[b]) shadow_cnt[b] = 0;

      // Lookups in an empty cache, then sizes out of range in each field.
      plan = {plan, plan_row_type'{op_item(KIND_FIND, 0, 1, 1, 0, 0, 0), 1'b1,
                       result_item(ST_NO_FIT, 0, 0, 0, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_READ, 0, 1, 1, 0, 0, 0), 1'b1,
                       result_item(ST_RANGE, 0, 0, 0, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_REMOVE, 3, 8, 8, 15, 0, 0), 1'b1,
                       result_item(ST_RANGE, 0, 0, 0, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_INSERT, 1, 0, 1, 0, 12, 34), 1'b1,
                       result_item(ST_BAD_SIZE, 0, 0, 0, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_INSERT, 2, 9, 8, 0, 255, 255), 1'b1,
                       result_item(ST_BAD_SIZE, 0, 0, 0, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_FIND, 3, 15, 15, 15, 0, 0), 1'b1,
                       result_item(ST_BAD_SIZE, 0, 0, 0, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_READ, 0, 1, 0, 0, 0, 0), 1'b1,
                       result_item(ST_BAD_SIZE, 0, 0, 0, 0, 0, 0), 5'd1}};
      // The largest class at the far corner, the smallest at the origin.
      plan = {plan, plan_row_type'{op_item(KIND_INSERT, 3, 8, 8, 0, 255, 255), 1'b1,
                       result_item(ST_OK, 0, 0, 1, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_INSERT, 0, 1, 1, 0, 0, 0), 1'b1,
                       result_item(ST_OK, 0, 0, 1, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_FIND, 0, 1, 1, 0, 0, 0), 1'b1,
                       result_item(ST_OK, 1, 1, 1, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_FIND, 3, 1, 1, 0, 0, 0), 1'b1,
                       result_item(ST_OK, 8, 8, 1, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_FIND, 0, 2, 1, 0, 0, 0), 1'b1,
                       result_item(ST_NO_FIT, 0, 0, 0, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_READ, 3, 8, 8, 0, 0, 0), 1'b1,
                       result_item(ST_OK, 0, 0, 1, 255, 255, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_READ, 3, 8, 8, 1, 0, 0), 1'b1,
                       result_item(ST_RANGE, 0, 0, 1, 0, 0, 0), 5'd1}};
      // Fill one bucket to the brim, then push one more into it.
      plan = {plan, plan_row_type'{op_item(KIND_INSERT, 2, 3, 5, 0, 165, 90), 1'b0, '0,
                       5'(DEPTH)}};
      plan = {plan, plan_row_type'{op_item(KIND_INSERT, 2, 3, 5, 0, 1, 2), 1'b1,
                       result_item(ST_FULL, 0, 0, DEPTH, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_READ, 2, 3, 5, 15, 0, 0), 1'b0, '0, 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_REMOVE, 2, 3, 5, 0, 0, 0), 1'b0, '0, 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_FIND, 2, 2, 2, 0, 0, 0), 1'b0, '0, 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_FIND, 2, 4, 4, 0, 0, 0), 1'b0, '0, 5'd1}};
      // Removing the only entry empties the bucket and clears its class.
      plan = {plan, plan_row_type'{op_item(KIND_REMOVE, 3, 8, 8, 0, 0, 0), 1'b1,
                       result_item(ST_OK, 0, 0, 0, 0, 0, 1), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_FIND, 3, 1, 1, 0, 0, 0), 1'b1,
                       result_item(ST_NO_FIT, 0, 0, 0, 0, 0, 0), 5'd1}};
      plan = {plan, plan_row_type'{op_item(KIND_REMOVE, 0, 1, 1, 0, 0, 0), 1'b1,
                       result_item(ST_OK, 0, 0, 0, 0, 0, 1), 5'd1}};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[p]) begin
         row = plan[p];
         for (n = 0; n < row.reps; n++)
            send_item(row.req, 1'b0, 1'b0, row.typed, row.rsp);
      end

      // Random part. The hot buckets move every 250 items; the first item
      // waits until the directed results are all back, and a few more
      // items hold off the same way along the run.
      calm = 1'b0;
      for (i = 0; i < RAND_ITEMS; i++) begin
         if (i % 250 == 0) begin
            hot_dir = 2'($urandom_range(0, DIRECTIONS - 1));
            foreach (hot_w[k]) begin
               hot_w[k] = 4'($urandom_range(1, MAX_SIDE));
               hot_h[k] = 4'($urandom_range(1, MAX_SIDE));
            end
         end
         if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         send_item(draw_op(), i == 0 || $urandom_range(0, 149) == 0, calm, 1'b0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_owed.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
